// ===== design/nlb_pkg.sv =====
// ----------------------------------------------------------------------------
// Notification LED blinker package
// Event codes, register indexes, reset values and the transaction payload
// types shared by the notification LED blinker.
// ----------------------------------------------------------------------------
package nlb_pkg;

    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned FUNC_BITS      = 4;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TICK        = 4'd0,
        FUNC_SUPPORT_ON  = 4'd1,
        FUNC_SUPPORT_OFF = 4'd2,
        FUNC_NOTIFY_ON   = 4'd3,
        FUNC_NOTIFY_OFF  = 4'd4,
        FUNC_BLINK_START = 4'd5,
        FUNC_BLINK_STOP  = 4'd6,
        FUNC_SUSPEND     = 4'd7,
        FUNC_RESUME      = 4'd8
    } func_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ON_INTERVAL  = 2'd0,
        REG_OFF_INTERVAL = 2'd1,
        REG_MAX_BLINKS   = 2'd2
    } reg_index_t;

    localparam logic [CFG_DATA_BITS-1:0] ON_INTERVAL_RESET  = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] OFF_INTERVAL_RESET = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] MAX_BLINKS_RESET   = 16'd300;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 driver_ready;
    } in_t;

    typedef struct packed {
        logic        led_lit;
        logic        notify_active;
        logic        blink_active;
        logic [15:0] blinks_left;
        logic        timed_out;
        logic        support_on;
    } out_t;

endpackage

// ===== design/notification_led_blinker.sv =====
// ----------------------------------------------------------------------------
// Notification LED blinker
// Event-driven controller for a notification LED with blink timing and a
// blink budget that ends the notification when it runs out.
// ----------------------------------------------------------------------------
// One transaction is accepted in every cycle while the result register is
// empty or being emptied; its result appears in the cycle after acceptance
// and is held in the result register until taken. All state updates for a
// transaction are made in a single pass of combinational logic ahead of
// the state and result registers: one transaction per cycle unless stalled.
module notification_led_blinker #(
    parameter int unsigned INTERVAL_BITS = 16,
    parameter int unsigned BUDGET_BITS   = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [nlb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nlb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  nlb_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output nlb_pkg::out_t                      m_data
);

    localparam int unsigned WIDE_BITS = BUDGET_BITS + 16;

    logic [nlb_pkg::CFG_DATA_BITS-1:0] on_interval_reg;
    logic [nlb_pkg::CFG_DATA_BITS-1:0] off_interval_reg;
    logic [nlb_pkg::CFG_DATA_BITS-1:0] max_blinks_reg;

    logic                     support_reg, support_next;
    logic                     sleep_reg, sleep_next;
    logic                     active_reg, active_next;
    logic                     blink_reg, blink_next;
    logic                     lamp_reg, lamp_next;
    logic [BUDGET_BITS-1:0]   budget_reg, budget_next;
    logic [INTERVAL_BITS-1:0] phase_reg, phase_next;
    logic                     timeout_next;

    logic                     m_valid_reg;
    nlb_pkg::out_t            m_data_reg;
    nlb_pkg::out_t            m_data_next;

    logic [INTERVAL_BITS-1:0] on_load;
    logic [INTERVAL_BITS-1:0] off_load;
    logic [INTERVAL_BITS-1:0] on_cast;
    logic [INTERVAL_BITS-1:0] off_cast;
    logic [BUDGET_BITS-1:0]   budget_dec;
    logic [WIDE_BITS-1:0]     budget_wide;
    logic                     accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign on_cast    = INTERVAL_BITS'(on_interval_reg);
    assign off_cast   = INTERVAL_BITS'(off_interval_reg);
    assign on_load    = (on_cast == '0) ? INTERVAL_BITS'(1) : on_cast;
    assign off_load   = (off_cast == '0) ? INTERVAL_BITS'(1) : off_cast;
    assign budget_dec = budget_reg - BUDGET_BITS'(1);

    always_comb begin
        support_next = support_reg;
        sleep_next   = sleep_reg;
        active_next  = active_reg;
        blink_next   = blink_reg;
        lamp_next    = lamp_reg;
        budget_next  = budget_reg;
        phase_next   = phase_reg;
        timeout_next = 1'b0;
        case (nlb_pkg::func_t'(s_data.func))
            nlb_pkg::FUNC_TICK: begin
                if (blink_reg) begin
                    if (phase_reg > INTERVAL_BITS'(1)) begin
                        phase_next = phase_reg - INTERVAL_BITS'(1);
                    end else if (lamp_reg) begin
                        if ((budget_reg != '0) && (budget_dec == '0)) begin
                            budget_next  = '0;
                            blink_next   = 1'b0;
                            phase_next   = '0;
                            lamp_next    = 1'b0;
                            active_next  = 1'b0;
                            timeout_next = 1'b1;
                        end else begin
                            if (budget_reg != '0) begin
                                budget_next = budget_dec;
                            end
                            lamp_next  = 1'b0;
                            phase_next = off_load;
                        end
                    end else begin
                        lamp_next  = 1'b1;
                        phase_next = on_load;
                    end
                end
            end
            nlb_pkg::FUNC_SUPPORT_ON: begin
                support_next = 1'b1;
            end
            nlb_pkg::FUNC_SUPPORT_OFF, nlb_pkg::FUNC_NOTIFY_OFF: begin
                if (s_data.func == nlb_pkg::FUNC_SUPPORT_OFF) begin
                    support_next = 1'b0;
                end
                if (active_reg) begin
                    if (blink_reg) begin
                        blink_next = 1'b0;
                        phase_next = '0;
                    end
                    lamp_next   = 1'b0;
                    active_next = 1'b0;
                end
            end
            nlb_pkg::FUNC_NOTIFY_ON: begin
                if (support_reg && !active_reg && sleep_reg && s_data.driver_ready) begin
                    lamp_next   = 1'b1;
                    active_next = 1'b1;
                end
            end
            nlb_pkg::FUNC_BLINK_START: begin
                if (active_reg && !blink_reg) begin
                    blink_next  = 1'b1;
                    phase_next  = on_load;
                    budget_next = BUDGET_BITS'(max_blinks_reg);
                end
            end
            nlb_pkg::FUNC_BLINK_STOP: begin
                if (blink_reg) begin
                    blink_next = 1'b0;
                    phase_next = '0;
                    if (active_reg) begin
                        lamp_next = 1'b1;
                    end
                end
            end
            nlb_pkg::FUNC_SUSPEND: begin
                sleep_next = 1'b1;
            end
            nlb_pkg::FUNC_RESUME: begin
                sleep_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign budget_wide = WIDE_BITS'(budget_next);

    always_comb begin
        m_data_next.led_lit       = lamp_next;
        m_data_next.notify_active = active_next;
        m_data_next.blink_active  = blink_next;
        m_data_next.blinks_left   = budget_wide[15:0];
        m_data_next.timed_out     = timeout_next;
        m_data_next.support_on    = support_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_interval_reg  <= nlb_pkg::ON_INTERVAL_RESET;
            off_interval_reg <= nlb_pkg::OFF_INTERVAL_RESET;
            max_blinks_reg   <= nlb_pkg::MAX_BLINKS_RESET;
        end else if (cfg_wr_en) begin
            case (nlb_pkg::reg_index_t'(cfg_index))
                nlb_pkg::REG_ON_INTERVAL:  on_interval_reg  <= cfg_wdata;
                nlb_pkg::REG_OFF_INTERVAL: off_interval_reg <= cfg_wdata;
                nlb_pkg::REG_MAX_BLINKS:   max_blinks_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            support_reg <= 1'b0;
            sleep_reg   <= 1'b0;
            active_reg  <= 1'b0;
            blink_reg   <= 1'b0;
            lamp_reg    <= 1'b0;
            budget_reg  <= '0;
            phase_reg   <= '0;
        end else if (accept) begin
            support_reg <= support_next;
            sleep_reg   <= sleep_next;
            active_reg  <= active_next;
            blink_reg   <= blink_next;
            lamp_reg    <= lamp_next;
            budget_reg  <= budget_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
